FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pcsf_pkg.sv
// ----------------------------------------------------------------------------
// pcsf_pkg
// Register map, enable and status bits, opcodes for the post code snoop FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package pcsf_pkg;

  localparam int unsigned RegCount = 10;

  localparam logic [3:0] RG_CMP2_LO = 4'd0;
  localparam logic [3:0] RG_CMP2_HI = 4'd1;
  localparam logic [3:0] RG_ENABLE  = 4'd2;
  localparam logic [3:0] RG_STATUS  = 4'd3;
  localparam logic [3:0] RG_DATA    = 4'd4;
  localparam logic [3:0] RG_CMP1_LO = 4'd7;
  localparam logic [3:0] RG_CMP1_HI = 4'd8;

  localparam logic [7:0] CMP1_LO_RESET = 8'h80;

  localparam int unsigned EN_CMP1_BIT  = 7;
  localparam int unsigned EN_CMP2_BIT  = 6;
  localparam int unsigned EN_FRAME_BIT = 3;
  localparam int unsigned EN_DWORD_BIT = 2;

  localparam int unsigned ST_VALID_BIT = 7;
  localparam int unsigned ST_OVF_BIT   = 5;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_SNOOP = 2'd2
  } opcode_e;

  typedef struct packed {
    logic       irq;
    logic [7:0] read_data;
  } pcsf_res_t;

endpackage

`default_nettype wire

FILE: rtl/pcsf_ram.sv
// ----------------------------------------------------------------------------
// pcsf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsf_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/post_code_snoop_fifo.sv
// ----------------------------------------------------------------------------
// post_code_snoop_fifo
// Post code snoop block: byte register file, head data/status pair, queue RAM.
// ----------------------------------------------------------------------------
// Flow: register accesses and ignored snoops go from accept to ST_HOLD, a data
// read that pops the queue passes ST_POP first (one RAM read), and a captured
// snoop stays in ST_PUSH for each byte, 1 byte normally and 1 to 4 in dword capture.
// ST_HOLD loads the result into the output register; the next word is taken once
// it sits there. Reset clears control state and the register file
// (compare1 low to 0x80); queue RAM contents stay undefined, no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module post_code_snoop_fifo #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] reg_offset, [15:8] write_data, [31:16] post_addr, [63:32] post_data
  input  wire logic [63:0] s_axis_tdata,
  // [1:0] opcode
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] read_data, [8] irq, [15:9] zero
  output logic [15:0]      m_axis_tdata
);

  import pcsf_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW = CW + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [7:0]    rf_q [RegCount];
  logic [7:0]    rf_d [RegCount];
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          irq_q, irq_d;
  logic [7:0]    res_q, res_d;
  logic [31:0]   shift_q, shift_d;
  logic          dword_q, dword_d;
  logic          mark_q, mark_d;
  logic          m_valid_q, m_valid_d;
  pcsf_res_t     m_res_q, m_res_d;

  logic          in_acc;
  opcode_e       opcode;
  logic [7:0]    reg_offset;
  logic [7:0]    write_data;
  logic [15:0]   post_addr;
  logic [3:0]    reg_idx;
  logic          reg_ok;
  logic          dword_en;
  logic          match1;
  logic          match2;
  logic          queue_full;
  logic [TW-1:0] tail_sum;
  logic [AW-1:0] tail_addr;
  logic [7:0]    push_data;
  logic          push_last;
  logic          push_mark;
  logic          pop_req;

  logic          ram_we;
  logic          ram_re;
  logic [8:0]    ram_rdata;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign opcode        = opcode_e'(s_axis_tuser);
  assign reg_offset    = s_axis_tdata[7:0];
  assign write_data    = s_axis_tdata[15:8];
  assign post_addr     = s_axis_tdata[31:16];
  assign reg_idx       = reg_offset[4:1];
  assign reg_ok        = !reg_offset[0] && (reg_offset[7:1] < 7'(RegCount));
  assign pop_req       = in_acc && (opcode == OP_READ) && reg_ok
                         && (reg_idx == RG_DATA) && (cnt_q != '0);

  assign dword_en = rf_q[RG_ENABLE][EN_DWORD_BIT];
  assign match1   = (dword_en || rf_q[RG_ENABLE][EN_CMP1_BIT])
                    && (post_addr == {rf_q[RG_CMP1_HI], rf_q[RG_CMP1_LO]});
  assign match2   = rf_q[RG_ENABLE][EN_CMP2_BIT]
                    && (post_addr == {rf_q[RG_CMP2_HI], rf_q[RG_CMP2_LO]});

  assign queue_full = (cnt_q == CW'(QUEUE_DEPTH));
  assign tail_sum   = TW'(head_q) + TW'(cnt_q);
  assign tail_addr  = (tail_sum >= TW'(QUEUE_DEPTH)) ? AW'(tail_sum - TW'(QUEUE_DEPTH))
                                                     : AW'(tail_sum);
  assign push_data  = shift_q[7:0];
  assign push_last  = !dword_q || (shift_q[31:8] == 24'd0);
  assign push_mark  = dword_q ? push_last : mark_q;
  assign ram_we     = (state_q == ST_PUSH) && !queue_full && rf_q[RG_STATUS][ST_VALID_BIT];

  always_comb begin
    state_d   = state_q;
    rf_d      = rf_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    irq_d     = irq_q;
    res_d     = res_q;
    shift_d   = shift_q;
    dword_d   = dword_q;
    mark_d    = mark_q;
    ram_re    = 1'b0;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_res_d   = m_res_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_d   = 8'd0;
          state_d = ST_HOLD;
          unique case (opcode)
            OP_READ: begin
              if (reg_ok) begin
                res_d = rf_q[reg_idx];
                if (reg_idx == RG_STATUS) begin
                  rf_d[RG_STATUS][ST_OVF_BIT] = 1'b0;
                end else if (reg_idx == RG_DATA) begin
                  if (cnt_q == '0) begin
                    rf_d[RG_STATUS][ST_VALID_BIT] = 1'b0;
                    irq_d = 1'b0;
                  end else begin
                    ram_re  = 1'b1;
                    state_d = ST_POP;
                  end
                end
              end
            end
            OP_WRITE: begin
              if (reg_ok) begin
                rf_d[reg_idx] = write_data;
              end
            end
            OP_SNOOP: begin
              if (match1 || (match2 && !dword_en)) begin
                shift_d = s_axis_tdata[63:32];
                dword_d = dword_en;
                mark_d  = !match1;
                state_d = ST_PUSH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        rf_d[RG_DATA]   = ram_rdata[7:0];
        rf_d[RG_STATUS] = {1'b1, 6'd0, ram_rdata[8]};
        head_d  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
        cnt_d   = cnt_q - CW'(1);
        irq_d   = rf_q[RG_ENABLE][EN_FRAME_BIT];
        state_d = ST_HOLD;
      end
      ST_PUSH: begin
        if (queue_full) begin
          rf_d[RG_STATUS][ST_OVF_BIT] = 1'b1;
        end else if (rf_q[RG_STATUS][ST_VALID_BIT]) begin
          cnt_d = cnt_q + CW'(1);
        end else begin
          rf_d[RG_DATA]   = push_data;
          rf_d[RG_STATUS] = {1'b1, 6'd0, push_mark};
        end
        shift_d = {8'd0, shift_q[31:8]};
        if (push_last) begin
          irq_d   = rf_q[RG_ENABLE][EN_FRAME_BIT] && rf_d[RG_STATUS][ST_VALID_BIT];
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d         = 1'b1;
          m_res_d.read_data = res_q;
          m_res_d.irq       = irq_q;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      cnt_q     <= '0;
      irq_q     <= 1'b0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < RegCount; i++) begin
        rf_q[i] <= (i == int'(RG_CMP1_LO)) ? CMP1_LO_RESET : 8'd0;
      end
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      irq_q     <= irq_d;
      m_valid_q <= m_valid_d;
      rf_q      <= rf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    shift_q <= shift_d;
    dword_q <= dword_d;
    mark_q  <= mark_d;
    m_res_q <= m_res_d;
  end

  pcsf_ram #(
    .WIDTH (9),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_addr),
    .wdata_i ({push_mark, push_data}),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_res_q};

  `ASSERT_IMPLIES(a_cnt_bound, 1'b1, cnt_q <= CW'(QUEUE_DEPTH), "queue count past depth")
  `ASSERT_IMPLIES(a_pop_nonempty, state_q == ST_POP, cnt_q != '0, "pop from empty queue")
  `ASSERT_NEXT(a_pop_issued, pop_req, state_q == ST_POP, "data read did not pop")
  `ASSERT_NEXT(a_ovf_on_full, state_q == ST_PUSH && queue_full, rf_q[RG_STATUS][ST_OVF_BIT], "full queue did not flag overflow")

endmodule

`default_nettype wire

FILE: tb/post_code_checker.sv
// ----------------------------------------------------------------------------
// post_code_checker
// Watches both streams of the post code snoop FIFO. Tracks the register file,
// the capture queue and the interrupt level for every accepted input word,
// and compares each result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module post_code_checker
  import pcsf_pkg::*;
#(
  parameter int unsigned QueueDepth = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [7:0] reg_offset, [15:8] write_data, [31:16] post_addr, [63:32] post_data
  input  logic [63:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_data, [8] irq, [15:9] zero
  input  logic [15:0] m_axis_tdata,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ST_MARK_BIT = 0;

  logic [7:0]  regs_q [RegCount];
  logic [7:0]  queue_byte [QueueDepth];
  logic        queue_mark [QueueDepth];
  int unsigned queue_cnt;
  int unsigned queue_head;
  logic        irq_lvl;
  pcsf_res_t   expected_results [$];
  int unsigned mismatches;

  task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
    mismatches++;
    $display("%0t ns: result word %s mismatch, expected 0x%0h, got 0x%0h",
             $time, what, want, got);
  endtask

  function automatic void refresh_irq();
    irq_lvl = regs_q[RG_ENABLE][EN_FRAME_BIT] & regs_q[RG_STATUS][ST_VALID_BIT];
  endfunction

  function automatic void load_head(logic [7:0] value, logic mark);
    regs_q[RG_DATA] = value;
    regs_q[RG_STATUS] = '0;
    regs_q[RG_STATUS][ST_VALID_BIT] = 1'b1;
    regs_q[RG_STATUS][ST_MARK_BIT] = mark;
  endfunction

  function automatic void capture_byte(logic [7:0] value, logic mark);
    int unsigned slot;
    if (queue_cnt >= QueueDepth) begin
      regs_q[RG_STATUS][ST_OVF_BIT] = 1'b1;
    end else if (regs_q[RG_STATUS][ST_VALID_BIT]) begin
      slot = (queue_head + queue_cnt) % QueueDepth;
      queue_byte[slot] = value;
      queue_mark[slot] = mark;
      queue_cnt++;
    end else begin
      load_head(value, mark);
    end
  endfunction

  function automatic logic [7:0] pop_data();
    logic [7:0] head;
    head = regs_q[RG_DATA];
    if (queue_cnt == 0) begin
      regs_q[RG_STATUS][ST_VALID_BIT] = 1'b0;
    end else begin
      load_head(queue_byte[queue_head], queue_mark[queue_head]);
      queue_head = (queue_head + 1) % QueueDepth;
      queue_cnt--;
    end
    refresh_irq();
    return head;
  endfunction

  function automatic void snoop_capture(logic [15:0] addr, logic [31:0] data);
    logic [7:0]  en;
    logic        dword;
    logic        hit1;
    logic        hit2;
    logic        last;
    logic [31:0] rest;
    en = regs_q[RG_ENABLE];
    dword = en[EN_DWORD_BIT];
    hit1 = (dword || en[EN_CMP1_BIT]) && addr == {regs_q[RG_CMP1_HI], regs_q[RG_CMP1_LO]};
    hit2 = !hit1 && en[EN_CMP2_BIT] && addr == {regs_q[RG_CMP2_HI], regs_q[RG_CMP2_LO]};
    if (hit1 || (hit2 && !dword)) begin
      if (dword) begin
        rest = data;
        last = 1'b0;
        while (!last) begin
          last = (rest[31:8] == '0);
          capture_byte(rest[7:0], last);
          rest = rest >> 8;
        end
      end else begin
        capture_byte(data[7:0], hit2);
      end
      refresh_irq();
    end
  endfunction

  function automatic pcsf_res_t apply_word(logic [1:0] op, logic [7:0] offset,
                                           logic [7:0] wdata, logic [15:0] addr,
                                           logic [31:0] data);
    pcsf_res_t  res;
    logic       ok;
    logic [3:0] idx;
    res = '0;
    ok = !offset[0] && (offset[7:1] < RegCount);
    idx = offset[4:1];
    case (op)
      OP_READ: begin
        if (ok) begin
          if (idx == RG_STATUS) begin
            res.read_data = regs_q[RG_STATUS];
            regs_q[RG_STATUS][ST_OVF_BIT] = 1'b0;
          end else if (idx == RG_DATA) begin
            res.read_data = pop_data();
          end else begin
            res.read_data = regs_q[idx];
          end
        end
      end
      OP_WRITE: begin
        if (ok) regs_q[idx] = wdata;
      end
      OP_SNOOP: begin
        snoop_capture(addr, data);
      end
      default: ;
    endcase
    res.irq = irq_lvl;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    pcsf_res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) regs_q[i] = '0;
      regs_q[RG_CMP1_LO] = CMP1_LO_RESET;
      queue_cnt = 0;
      queue_head = 0;
      irq_lvl = 1'b0;
      mismatches = 0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("with nothing pending", '0, m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[7:0] !== want.read_data)
            report_mismatch("read_data", 16'(want.read_data), 16'(m_axis_tdata[7:0]));
          if (m_axis_tdata[8] !== want.irq)
            report_mismatch("irq", 16'(want.irq), 16'(m_axis_tdata[8]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(apply_word(s_axis_tuser, s_axis_tdata[7:0],
                                              s_axis_tdata[15:8], s_axis_tdata[31:16],
                                              s_axis_tdata[63:32]));
    end
    fail_count_o <= mismatches;
    pending_o <= expected_results.size();
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives register reads and writes and snooped post code writes into the
// post code snoop FIFO: a directed pass over the corner cases, then random
// capture bursts and noise under varying source and sink idling.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pcsf_pkg::*;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned ResetCycles = 5;
  localparam int unsigned QueueDepth  = 16;
  localparam int unsigned WordCount   = 510;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned HoldAt      = 60;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 20;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [3:0] RG_MISC     = 4'd5;
  localparam logic [3:0] RG_RESERVED = 4'd6;
  localparam logic [3:0] RG_SCRATCH  = 4'd9;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned stall_cycles = 0;
  logic        hold_off_req = 1'b0;
  logic [15:0] cmp1_addr = {8'h00, CMP1_LO_RESET};
  logic [15:0] cmp2_addr = '0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  post_code_snoop_fifo #(
    .QUEUE_DEPTH(QueueDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  post_code_checker #(
    .QueueDepth(QueueDepth)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic logic [7:0] en_bits(logic cmp1, logic cmp2, logic frame, logic dword);
    logic [7:0] en;
    en = '0;
    en[EN_CMP1_BIT] = cmp1;
    en[EN_CMP2_BIT] = cmp2;
    en[EN_FRAME_BIT] = frame;
    en[EN_DWORD_BIT] = dword;
    return en;
  endfunction

  function automatic logic [15:0] pick_addr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return cmp1_addr;
    if (r < 80) return cmp2_addr;
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_data();
    return 32'($urandom) >> (8 * $urandom_range(0, 4));
  endfunction

  task automatic send_word(logic [1:0] op, logic [7:0] offset, logic [7:0] wdata,
                           logic [15:0] addr, logic [31:0] data);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {data, addr, wdata, offset};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
    if (op == OP_WRITE && !offset[0] && offset[7:1] < RegCount) begin
      case (offset[4:1])
        RG_CMP1_LO: cmp1_addr[7:0] = wdata;
        RG_CMP1_HI: cmp1_addr[15:8] = wdata;
        RG_CMP2_LO: cmp2_addr[7:0] = wdata;
        RG_CMP2_HI: cmp2_addr[15:8] = wdata;
        default: ;
      endcase
    end
  endtask

  task automatic write_reg(logic [3:0] idx, logic [7:0] value);
    send_word(OP_WRITE, {3'b000, idx, 1'b0}, value, 16'($urandom), 32'($urandom));
  endtask

  task automatic read_reg(logic [3:0] idx);
    send_word(OP_READ, {3'b000, idx, 1'b0}, 8'($urandom), 16'($urandom), 32'($urandom));
  endtask

  task automatic snoop(logic [15:0] addr, logic [31:0] data);
    send_word(OP_SNOOP, 8'($urandom), 8'($urandom), addr, data);
  endtask

  task automatic random_word();
    logic [1:0]  op;
    logic [7:0]  offset;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) op = OP_UNUSED;
    else if (pick < 35) op = OP_READ;
    else if (pick < 60) op = OP_WRITE;
    else op = OP_SNOOP;
    if ($urandom_range(0, 3) == 0) offset = 8'($urandom);
    else offset = {3'b000, 4'($urandom_range(0, RegCount - 1)), 1'b0};
    send_word(op, offset, 8'($urandom), pick_addr(), pick_data());
  endtask

  task automatic capture_burst();
    logic [7:0]  en;
    logic [15:0] addr;
    int unsigned n_snoops;
    if ($urandom_range(0, 2) == 0) begin
      en = 8'($urandom);
      if ($urandom_range(0, 3) != 0) en[EN_CMP1_BIT] = 1'b1;
      write_reg(RG_ENABLE, en);
    end
    if ($urandom_range(0, 3) == 0) begin
      addr = 16'($urandom);
      write_reg(RG_CMP1_LO, addr[7:0]);
      write_reg(RG_CMP1_HI, addr[15:8]);
    end
    if ($urandom_range(0, 3) == 0) begin
      addr = ($urandom_range(0, 4) == 0) ? cmp1_addr : 16'($urandom);
      write_reg(RG_CMP2_LO, addr[7:0]);
      write_reg(RG_CMP2_HI, addr[15:8]);
    end
    n_snoops = $urandom_range(1, 8);
    repeat (n_snoops) snoop(pick_addr(), pick_data());
    if ($urandom_range(0, 1) == 0) read_reg(RG_STATUS);
    repeat ($urandom_range(0, 2 * n_snoops + 2)) begin
      read_reg(RG_DATA);
      if ($urandom_range(0, 3) == 0) read_reg(RG_STATUS);
    end
  endtask

  // sink side: random stalls, plus one long hold-off on request
  initial begin : sink
    int unsigned hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && hold_left == 0) begin
        hold_left = HoldCycles;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (rst_ni) begin
      if (stall_cycles >= StallLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : source
    int unsigned random_start;
    int unsigned done;
    logic        hold_done;
    hold_done = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values, invalid offsets
    read_reg(RG_STATUS);
    read_reg(RG_CMP1_LO);
    send_word(OP_READ, 8'h0F, 8'h00, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(OP_READ, 8'hFF, 8'hFF, 16'h0000, 32'h0000_0000);
    send_word(OP_READ, {3'b000, 4'(RegCount), 1'b0}, 8'h00, 16'h0000, 32'h0);
    send_word(OP_WRITE, 8'h0F, 8'hFF, 16'h0000, 32'h0);
    send_word(OP_WRITE, 8'hFE, 8'hFF, 16'h0000, 32'h0);
    // normal capture on both compares, drain past empty
    write_reg(RG_ENABLE, en_bits(1'b1, 1'b0, 1'b1, 1'b0));
    snoop(cmp1_addr, 32'hFFFF_FFA5);
    snoop(cmp1_addr + 16'd1, 32'h0000_0011);
    write_reg(RG_CMP2_LO, 8'hFF);
    write_reg(RG_CMP2_HI, 8'hFF);
    write_reg(RG_ENABLE, en_bits(1'b1, 1'b1, 1'b1, 1'b0));
    snoop(cmp2_addr, 32'h0000_005A);
    repeat (3) read_reg(RG_DATA);
    // dword capture: zero, four bytes, two bytes, compare2 ignored, overflow
    write_reg(RG_ENABLE, en_bits(1'b0, 1'b1, 1'b1, 1'b1));
    snoop(cmp1_addr, 32'h0000_0000);
    snoop(cmp1_addr, 32'h1234_5678);
    snoop(cmp1_addr, 32'h0000_0100);
    snoop(cmp2_addr, 32'h0000_00FF);
    repeat (3) snoop(cmp1_addr, 32'hFFFF_FFFF);
    repeat (2) read_reg(RG_STATUS);
    // plain stores into status, data and spare registers
    write_reg(RG_STATUS, 8'h00);
    write_reg(RG_DATA, 8'h33);
    read_reg(RG_DATA);
    write_reg(RG_RESERVED, 8'hFF);
    write_reg(RG_SCRATCH, 8'hA5);
    read_reg(RG_MISC);
    send_word(OP_UNUSED, {3'b000, RG_SCRATCH, 1'b0}, 8'h5A, 16'h0000, 32'h0);

    random_start = words_sent;
    done = 0;
    while (done < WordCount) begin
      case (done * 4 / WordCount)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 47;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 47;
        end
        default: begin
          tx_idle_pct = 33;
          rx_stall_pct = 33;
        end
      endcase
      if (!hold_done && done >= HoldAt) begin
        hold_done = 1'b1;
        hold_off_req = 1'b1;
        repeat (8) snoop(pick_addr(), pick_data());
        repeat (8) read_reg(RG_DATA);
      end else if ($urandom_range(0, 99) < 55) begin
        capture_burst();
      end else begin
        random_word();
      end
      done = words_sent - random_start;
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pcsf_pkg.sv
rtl/pcsf_ram.sv
rtl/post_code_snoop_fifo.sv
tb/post_code_checker.sv
tb/testbench.sv
